FILE: src/msbbr_pkg.sv
// shared types, constants and codes for the msb-first bit reader
`timescale 1ns / 1ps

package msbbr_pkg;

  // default sizes
  localparam int BUFFER_BYTES_DEF = 4096;
  localparam int WINDOW_BITS_DEF  = 64;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int ADV_W     = 16;
  localparam int VALUE_W   = 64;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 72;

  // banked store geometry: sixteen byte-wide banks, nine bytes per fetch
  localparam int NBANK     = 16;
  localparam int BANK_W    = 4;
  localparam int WIN_BYTES = 9;
  localparam int WIN_W     = WIN_BYTES * BYTE_W;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  // extraction request: where in the window and how many bits
  typedef struct packed {
    logic [2:0]       bit_off;
    logic [LEN_W-1:0] len;
  } xreq_t;

endpackage

FILE: src/msbbr_bank_mem.sv
// one byte-wide bank of the buffer store, registered read
`timescale 1ns / 1ps

module msbbr_bank_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [msbbr_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [msbbr_pkg::BYTE_W-1:0] rdata
);
  import msbbr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/msbbr_extract.sv
// bit extraction from the nine-byte fetch window
`timescale 1ns / 1ps

module msbbr_extract #(
  parameter int WINDOW_BITS = msbbr_pkg::WINDOW_BITS_DEF
) (
  input  logic [msbbr_pkg::BYTE_W-1:0]    win_bytes [msbbr_pkg::WIN_BYTES],
  input  logic [msbbr_pkg::WIN_BYTES-1:0] win_valid,
  input  msbbr_pkg::xreq_t               req,
  output logic [msbbr_pkg::VALUE_W-1:0]   value
);
  import msbbr_pkg::*;

  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   shifted;
  logic [VALUE_W-1:0] top;
  logic [LEN_W-1:0]   len_sat;
  logic [LEN_W-1:0]   rsh;

  // first byte lands in the top bits, bytes past the data end read as zero
  always_comb begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      win[WIN_W-1-k*BYTE_W -: BYTE_W] = win_valid[k] ? win_bytes[k] : '0;
    end
  end

  // drop bits already consumed in the first byte, then right align
  always_comb begin
    shifted = win << req.bit_off;
    top     = shifted[WIN_W-1 -: VALUE_W];
    len_sat = (req.len > LEN_W'(WINDOW_BITS)) ? LEN_W'(WINDOW_BITS) : req.len;
    rsh     = LEN_W'(VALUE_W) - len_sat;
    value   = top >> rsh;
  end

endmodule

FILE: src/msbbr_ctrl.sv
// command sequencing, position tracking and bank addressing
`timescale 1ns / 1ps

module msbbr_ctrl #(
  parameter int BUFFER_BYTES = msbbr_pkg::BUFFER_BYTES_DEF,
  parameter int WINDOW_BITS  = msbbr_pkg::WINDOW_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [msbbr_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [msbbr_pkg::CMD_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [msbbr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import msbbr_pkg::*;

  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int ROWS   = (BUFFER_BYTES + NBANK - 1) / NBANK;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RA_W   = CNT_W - BANK_W;
  localparam int POS_W  = CNT_W + 3;
  localparam int SUM_W  = ((POS_W > ADV_W) ? POS_W : ADV_W) + 1;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic [2:0]         bit_pos_r, bit_pos_nxt;
  logic [LEN_W-1:0]   len_r;
  logic [ADV_W-1:0]   adv_r;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  cmd_t               cmd;
  logic [BYTE_W-1:0]  in_byte;
  logic               accept;
  logic               rd_issue;
  logic               append_ok;
  logic               finish;

  logic [BYTE_W-1:0]  bank_rdata [NBANK];
  logic [ROW_W-1:0]   bank_raddr [NBANK];
  logic [NBANK-1:0]   bank_we;
  logic [ROW_W-1:0]   bank_waddr;

  logic [BYTE_W-1:0]    win_bytes [WIN_BYTES];
  logic [WIN_BYTES-1:0] win_valid;
  xreq_t                xreq;
  logic [VALUE_W-1:0]   value;

  logic [SUM_W-1:0]   cur_pos, new_pos, end_pos, clamp_pos;
  logic               over;
  logic               more;

  // input beat decode
  assign cmd       = cmd_t'(in_tuser);
  assign in_byte   = in_tdata[BYTE_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign rd_issue  = accept && (cmd == CMD_READ);
  assign append_ok = accept && (cmd == CMD_APPEND) &&
                     (byte_count_r < CNT_W'(BUFFER_BYTES));

  // append goes to bank count mod 16, row count / 16
  assign bank_waddr = ROW_W'(byte_count_r >> BANK_W);
  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      bank_we[b] = append_ok && (byte_count_r[BANK_W-1:0] == BANK_W'(b));
    end
  end

  // banks below the start bank hold the next row of the window
  always_comb begin
    logic [RA_W-1:0] base_row;
    base_row = RA_W'(byte_pos_r >> BANK_W);
    for (int b = 0; b < NBANK; b++) begin
      if (BANK_W'(b) < byte_pos_r[BANK_W-1:0]) begin
        bank_raddr[b] = ROW_W'(base_row + RA_W'(1));
      end else begin
        bank_raddr[b] = ROW_W'(base_row);
      end
    end
  end

  // store banks
  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    msbbr_bank_mem #(
      .DEPTH  (ROWS),
      .ADDR_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr),
      .wdata (in_byte),
      .re    (rd_issue),
      .raddr (bank_raddr[g]),
      .rdata (bank_rdata[g])
    );
  end

  // rotate bank outputs into window order and mark bytes below the count
  always_comb begin
    logic [BANK_W-1:0] bsel;
    logic [CNT_W:0]    lane_addr;
    for (int k = 0; k < WIN_BYTES; k++) begin
      bsel         = byte_pos_r[BANK_W-1:0] + BANK_W'(k);
      win_bytes[k] = bank_rdata[bsel];
      lane_addr    = (CNT_W+1)'(byte_pos_r) + (CNT_W+1)'(k);
      win_valid[k] = lane_addr < (CNT_W+1)'(byte_count_r);
    end
  end

  assign xreq.bit_off = bit_pos_r;
  assign xreq.len     = len_r;

  msbbr_extract #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_extract (
    .win_bytes (win_bytes),
    .win_valid (win_valid),
    .req       (xreq),
    .value     (value)
  );

  // advance with clamp at the data end
  always_comb begin
    cur_pos   = SUM_W'({byte_pos_r, bit_pos_r});
    end_pos   = SUM_W'({byte_count_r, 3'b000});
    new_pos   = cur_pos + SUM_W'(adv_r);
    over      = new_pos > end_pos;
    clamp_pos = over ? end_pos : new_pos;
    more      = clamp_pos < end_pos;
  end

  assign finish = (state_r == S_FETCH) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt      = state_r;
    byte_count_nxt = byte_count_r;
    byte_pos_nxt   = byte_pos_r;
    bit_pos_nxt    = bit_pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_APPEND: begin
              if (append_ok) begin
                byte_count_nxt = byte_count_r + CNT_W'(1);
              end
            end
            CMD_READ: begin
              state_nxt = S_FETCH;
            end
            CMD_REWIND: begin
              byte_pos_nxt = '0;
              bit_pos_nxt  = '0;
            end
            CMD_CLEAR: begin
              byte_count_nxt = '0;
              byte_pos_nxt   = '0;
              bit_pos_nxt    = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (finish) begin
          state_nxt     = S_IDLE;
          byte_pos_nxt  = clamp_pos[POS_W-1:3];
          bit_pos_nxt   = clamp_pos[2:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      byte_count_r <= '0;
      byte_pos_r   <= '0;
      bit_pos_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      byte_pos_r   <= byte_pos_nxt;
      bit_pos_r    <= bit_pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // read request fields
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      len_r <= in_tdata[BYTE_W +: LEN_W];
      adv_r <= in_tdata[BYTE_W+LEN_W +: ADV_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {6'b0, over, more, value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/msb_first_bit_reader_unit.sv
// top level of the msb-first bit reader
`timescale 1ns / 1ps

// Bit reader over a byte buffer of BUFFER_BYTES entries, bits taken most
// significant first. The command travels in in_tuser: append a byte, read
// then advance, rewind to the start, or clear. Append, rewind and clear are
// done in the idle state and give no result beat; an append to a full buffer
// is dropped. A read first fetches nine consecutive bytes from the sixteen
// store banks at once (one registered bank read port each); then, in the
// fetch state, it shifts out up to WINDOW_BITS bits, right aligned, advances
// the position (clamped at the data end) and loads the result register. A
// result beat waiting on out_tready holds the reader only when the next read
// finishes. Bits past the end of the data read as zero. No clearing pass is
// needed after reset; the store contents are only read below the byte count.
module msb_first_bit_reader_unit #(
  parameter int BUFFER_BYTES = msbbr_pkg::BUFFER_BYTES_DEF,
  parameter int WINDOW_BITS  = msbbr_pkg::WINDOW_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // load_byte [7:0], read_length [14:8], advance_bits [30:15], zero [31]
  input  logic [msbbr_pkg::IN_DATA_W-1:0]  in_tdata,
  // command [1:0]
  input  logic [msbbr_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // bits_value [63:0], has_more [64], overrun [65], zero [71:66]
  output logic [msbbr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import msbbr_pkg::*;

  msbbr_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .WINDOW_BITS  (WINDOW_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: tb/tb_msb_first_bit_reader_unit.sv
// testbench for the msb-first bit reader: shadow byte store, ordered result checks
`timescale 1ns / 1ps

module tb_msb_first_bit_reader_unit;
  import msbbr_pkg::*;

  localparam int STORE_BYTES = BUFFER_BYTES_DEF;
  localparam int MAX_CYCLES  = 400000;

  // expected contents of one result beat
  typedef struct packed {
    logic [VALUE_W-1:0] bits_value;
    logic               has_more;
    logic               overrun;
  } read_result_t;

  // shadow of the reader state and the queue of reads still owed by the block
  class bit_read_tracker;
    logic [BYTE_W-1:0] shadow_bytes [STORE_BYTES];
    int unsigned       shadow_count;
    int unsigned       shadow_bitpos;
    read_result_t      owed_reads [$];
    int unsigned       errors;

    function new();
      shadow_count  = 0;
      shadow_bitpos = 0;
      errors        = 0;
    endfunction

    // update the shadow for an accepted beat; a read queues its result
    function void note_item(cmd_t cmd, logic [BYTE_W-1:0] lb, logic [LEN_W-1:0] len,
                            logic [ADV_W-1:0] adv);
      int unsigned nbits;
      int unsigned endp;
      int unsigned p;
      int unsigned idx;
      read_result_t r;
      case (cmd)
        CMD_APPEND: begin
          if (shadow_count < STORE_BYTES) begin
            shadow_bytes[shadow_count] = lb;
            shadow_count++;
          end
        end
        CMD_REWIND: begin
          shadow_bitpos = 0;
        end
        CMD_CLEAR: begin
          shadow_count  = 0;
          shadow_bitpos = 0;
        end
        default: begin
          nbits = (len > WINDOW_BITS_DEF) ? WINDOW_BITS_DEF : len;
          r = '0;
          // gather bits msb first, zero past the stored data
          for (int k = 0; k < nbits; k++) begin
            p   = shadow_bitpos + k;
            idx = p >> 3;
            r.bits_value = {r.bits_value[VALUE_W-2:0],
                            (idx < shadow_count) ? shadow_bytes[idx][7 - (p & 7)] : 1'b0};
          end
          // advance, clamped at the data end
          endp = shadow_count * 8;
          p    = shadow_bitpos + adv;
          if (p > endp) begin
            p = endp;
            r.overrun = 1'b1;
          end
          shadow_bitpos = p;
          r.has_more = (p < endp);
          owed_reads.push_back(r);
        end
      endcase
    endfunction

    // compare a result beat with the oldest owed read
    function void check_beat(logic [OUT_DATA_W-1:0] data);
      read_result_t exp_r;
      if (owed_reads.size() == 0) begin
        $error("unexpected result beat: %h", data);
        errors++;
      end else begin
        exp_r = owed_reads.pop_front();
        if (data[63:0] !== exp_r.bits_value) begin
          $error("bits_value: expected %h, got %h", exp_r.bits_value, data[63:0]);
          errors++;
        end
        if (data[64] !== exp_r.has_more) begin
          $error("has_more: expected %0d, got %0d", exp_r.has_more, data[64]);
          errors++;
        end
        if (data[65] !== exp_r.overrun) begin
          $error("overrun: expected %0d, got %0d", exp_r.overrun, data[65]);
          errors++;
        end
      end
    endfunction

    function int unsigned owed();
      return owed_reads.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = CMD_APPEND;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  bit                    gaps_on    = 1'b1;
  int unsigned           cycles     = 0;
  bit_read_tracker       tracker    = new();

  msb_first_bit_reader_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb_msb_first_bit_reader_unit: FAIL");
      $finish;
    end
  end

  // result side: check accepted beats, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        tracker.check_beat(out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rst_n && gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // present one beat, optionally after a gap, and wait for its acceptance
  task automatic send_item(cmd_t cmd, logic [BYTE_W-1:0] lb, logic [LEN_W-1:0] len,
                           logic [ADV_W-1:0] adv);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, adv, len, lb};
    do @(posedge clk); while (!in_tready);
    tracker.note_item(cmd, lb, len, adv);
  endtask

  // hold the input side until every owed read has come back
  task automatic drain_reads();
    in_tvalid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [LEN_W-1:0] len;
    logic [ADV_W-1:0] adv;
    pick = $urandom_range(0, 9);
    len = (pick == 0) ? 7'd0 : (pick == 1) ? LEN_W'($urandom_range(65, 127))
                                           : LEN_W'($urandom_range(1, 64));
    pick = $urandom_range(0, 9);
    adv = (pick < 6) ? ADV_W'($urandom_range(0, 72)) :
          (pick < 8) ? ADV_W'($urandom_range(0, 600)) : ADV_W'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_item(CMD_APPEND, BYTE_W'($urandom_range(0, 255)), len, adv);
    else if (pick < 88)
      send_item(CMD_READ, BYTE_W'($urandom_range(0, 255)), len, adv);
    else if (pick < 97)
      send_item(CMD_REWIND, BYTE_W'($urandom_range(0, 255)), len, adv);
    else
      send_item(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)), len, adv);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty buffer, field extremes, length and advance corner cases
    send_item(CMD_READ,   8'h00, 7'd64,  16'd0);
    send_item(CMD_READ,   8'h00, 7'd1,   16'd5);
    send_item(CMD_APPEND, 8'h00, 7'd0,   16'd0);
    send_item(CMD_APPEND, 8'hFF, 7'd0,   16'd0);
    send_item(CMD_APPEND, 8'hA5, 7'd0,   16'd0);
    send_item(CMD_APPEND, 8'h5A, 7'd0,   16'd0);
    send_item(CMD_APPEND, 8'h80, 7'd0,   16'd0);
    send_item(CMD_APPEND, 8'h01, 7'd0,   16'd0);
    send_item(CMD_READ,   8'h00, 7'd0,   16'd3);
    send_item(CMD_READ,   8'h00, 7'd1,   16'd1);
    send_item(CMD_READ,   8'h00, 7'd127, 16'd0);
    send_item(CMD_READ,   8'h00, 7'd65,  16'd12);
    send_item(CMD_REWIND, 8'hFF, 7'd127, 16'hFFFF);
    send_item(CMD_READ,   8'h00, 7'd64,  16'd48);
    send_item(CMD_READ,   8'h00, 7'd8,   16'd0);
    send_item(CMD_REWIND, 8'h00, 7'd0,   16'd0);
    send_item(CMD_READ,   8'hFF, 7'd40,  16'hFFFF);
    send_item(CMD_CLEAR,  8'hFF, 7'd127, 16'hFFFF);
    send_item(CMD_READ,   8'h00, 7'd16,  16'd1);
    send_item(CMD_APPEND, 8'h3C, 7'd0,   16'd0);
    send_item(CMD_READ,   8'h00, 7'd7,   16'h8000);
    drain_reads();

    // forty bytes, then reads that walk up to and past the data end
    send_item(CMD_CLEAR, 8'h00, 7'd0, 16'd0);
    for (int i = 0; i < 40; i++)
      send_item(CMD_APPEND, BYTE_W'($urandom_range(0, 255)), 7'd0, 16'd0);
    send_item(CMD_READ, 8'h00, 7'd64, 16'd300);
    send_item(CMD_READ, 8'h00, 7'd64, 16'd17);
    send_item(CMD_READ, 8'h00, 7'd64, 16'd7);
    send_item(CMD_READ, 8'h00, 7'd64, 16'd0);
    send_item(CMD_REWIND, 8'h00, 7'd0, 16'd0);
    for (int i = 0; i < 12; i++)
      send_item(CMD_READ, 8'h00, LEN_W'($urandom_range(0, 127)),
                ADV_W'($urandom_range(0, 65535)));
    drain_reads();
    send_item(CMD_CLEAR, 8'h00, 7'd0, 16'd0);

    // random traffic; the tail runs without gaps or stalls
    for (int i = 0; i < 460; i++) begin
      if (i == 380)
        gaps_on = 1'b0;
      if (i == 190)
        drain_reads();
      send_random_item();
    end
    in_tvalid <= 1'b0;

    // wait out the owed reads and the read latency
    while (tracker.owed() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0)
      $display("tb_msb_first_bit_reader_unit: PASS");
    else
      $display("tb_msb_first_bit_reader_unit: FAIL");
    $finish;
  end

endmodule

FILE: files.f
src/msbbr_pkg.sv
src/msbbr_bank_mem.sv
src/msbbr_extract.sv
src/msbbr_ctrl.sv
src/msb_first_bit_reader_unit.sv
tb/tb_msb_first_bit_reader_unit.sv
